// File: src/pwp_pkg.sv
// Shared constants, palette and colour mix function for the wallpaper pixel generator.
package pwp_pkg;

    typedef logic [23:0] t_rgb;

    localparam int MAX_DIM_DEF = 4096;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_THEME  = 2'd2;

    localparam logic [1:0] THEME_DAY   = 2'd0;
    localparam logic [1:0] THEME_OCEAN = 2'd1;
    localparam logic [1:0] THEME_NIGHT = 2'd2;

    localparam logic [2:0] SLOT_SKY_L  = 3'd0;
    localparam logic [2:0] SLOT_SKY_R  = 3'd1;
    localparam logic [2:0] SLOT_MIST_L = 3'd2;
    localparam logic [2:0] SLOT_MIST_R = 3'd3;
    localparam logic [2:0] SLOT_GLOW   = 3'd4;
    localparam logic [2:0] SLOT_WASH   = 3'd5;
    localparam logic [2:0] SLOT_HILL   = 3'd6;
    localparam logic [2:0] SLOT_EDGE   = 3'd7;

    localparam int DIV_NW = 20;
    localparam int DIV_DW = 13;
    localparam int DIV_QW = 9;

    localparam logic [31:0] HASH_C1 = 32'd374761393;
    localparam logic [31:0] HASH_C2 = 32'd668265263;
    localparam logic [31:0] HASH_C3 = 32'd1274126177;

    // reciprocals: ceil(2^s / d)
    localparam int K100_S28   = 2684355;
    localparam int K100_S19   = 5243;
    localparam int K800_S27   = 167773;
    localparam int K20000_S40 = 54975582;
    localparam int K40000_S40 = 27487791;
    localparam int K6_S10     = 171;

    localparam int SUN_R2     = 40000;
    localparam int VIG_SAT_IN = 112800;
    localparam int VIG_MAX    = 140;
    localparam int HILL_DSAT  = 79;
    localparam int HILL_TMAX  = 200;
    localparam int HILL_TOFS  = 40;
    localparam int WASH_WGT   = 14;

    localparam t_rgb PAL_TAB [0:2][0:7] = '{
        '{24'hE4EAF0, 24'hEEF2F6, 24'hC8D2DC, 24'hB8C4D0,
          24'hF3EDE2, 24'hD5DEE8, 24'h9AA8B6, 24'hA8B4C0},
        '{24'hD8ECF4, 24'hB9DCEA, 24'h89B8CC, 24'h6CA2BA,
          24'hE7F8FF, 24'hBBDDEA, 24'h477F98, 24'h5A899D},
        '{24'h253247, 24'h182235, 24'h172033, 24'h0F172A,
          24'h6B6A91, 24'h334155, 24'h0B1220, 24'h111827}
    };

    function automatic t_rgb palette(input logic [1:0] th, input logic [2:0] slot);
        t_rgb res;
        case (th)
            THEME_OCEAN: res = PAL_TAB[1][slot];
            THEME_NIGHT: res = PAL_TAB[2][slot];
            default:     res = PAL_TAB[0][slot];
        endcase
        return res;
    endfunction

    // per-channel a + (b - a) * w / 256, truncating toward zero
    function automatic t_rgb blend(input t_rgb a, input t_rgb b, input logic [9:0] wgt);
        t_rgb res;
        logic [7:0] ca;
        logic [7:0] cb;
        logic signed [9:0] diff;
        logic signed [19:0] prod;
        res = a;
        if (wgt >= 10'd256) begin
            res = b;
        end else if (wgt != 10'd0) begin
            for (int ch = 0; ch < 3; ch++) begin
                ca   = a[ch*8 +: 8];
                cb   = b[ch*8 +: 8];
                diff = $signed({2'b00, cb}) - $signed({2'b00, ca});
                prod = diff * $signed({1'b0, wgt[8:0]});
                if (prod < 0) begin
                    prod = prod + 20'sd255;
                end
                res[ch*8 +: 8] = ca + prod[15:8];
            end
        end
        return res;
    endfunction

endpackage

// File: src/pwp_div.sv
// Pipelined restoring divider, quotient saturated to all ones.
module pwp_div
    import pwp_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW,
    parameter int QW = DIV_QW
) (
    input  logic          i_clk,
    input  logic [QW:0]   i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int SW = DW + QW;

    logic [NW-1:0] r_rem [0:QW-1];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_quo [0:QW];
    logic          r_sat [0:QW];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_sat[0] <= SW'(i_num) >= {i_den, {QW{1'b0}}};
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_bit
        logic [SW-1:0] dsh;
        logic          fit;
        assign dsh = SW'(r_den[k-1]) << (QW - k);
        assign fit = !r_sat[k-1] && (SW'(r_rem[k-1]) >= dsh);

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_quo[k] <= r_quo[k-1] | (QW'(fit) << (QW - k));
                r_sat[k] <= r_sat[k-1];
            end
        end

        if (k < QW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rem[k] <= fit ? NW'(SW'(r_rem[k-1]) - dsh) : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_quo = r_sat[QW] ? {QW{1'b1}} : r_quo[QW];

endmodule

// File: src/procedural_wallpaper_pixel.sv
// Procedural wallpaper pixel generator, top level.
//
// Input channel: i_valid / o_stall carry one word, a pixel coordinate
// (i_pixel_x, i_pixel_y). Output channel: o_valid / i_stall carry one word,
// the 24-bit colour o_rgb (red 23:16, green 15:8, blue 7:0).
// A word moves when valid is high and stall is low at a rising edge.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 width, 1 height, 2 theme); write only while the pipeline is empty.
// Throughput: one pixel per clock while the receiver does not stall, set by the
// 17-stage pipeline in which each of four 9-step dividers retires one quotient
// bit per stage.
// Bubbles are squeezed out: o_stall only rises when every stage holds a word
// and the receiver stalls; stalled words are held, none lost or repeated.
// Reset (synchronous, active low) empties the pipeline and restores width
// 1024, height 768 and the daylight theme.
module procedural_wallpaper_pixel
    import pwp_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [23:0] o_rgb,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data
);

    localparam int NS = 17;

    logic [12:0] r_cfg_w;
    logic [12:0] r_cfg_h;
    logic [1:0]  r_theme;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 13'd1024;
            r_cfg_h <= 13'd768;
            r_theme <= THEME_DAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                CFG_THEME:  r_theme <= i_cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    // derived geometry
    logic [12:0] w_e;
    logic [12:0] h_e;
    logic [19:0] mx_n;
    logic [19:0] my_n;
    logic [19:0] hb_n;
    logic [41:0] mx_p;
    logic [41:0] my_p;
    logic [41:0] hb_p;

    always_comb begin
        w_e = r_cfg_w;
        if (r_cfg_w == 13'd0) begin
            w_e = 13'd1;
        end else if ({3'b000, r_cfg_w} > 16'(MAX_DIM)) begin
            w_e = 13'(MAX_DIM);
        end
        h_e = r_cfg_h;
        if (r_cfg_h == 13'd0) begin
            h_e = 13'd1;
        end else if ({3'b000, r_cfg_h} > 16'(MAX_DIM)) begin
            h_e = 13'(MAX_DIM);
        end
    end

    assign mx_n = {7'd0, w_e} * 20'd24;
    assign my_n = {7'd0, h_e} * 20'd20;
    assign hb_n = {7'd0, h_e} * 20'd74;
    assign mx_p = 42'(mx_n) * 42'(K100_S28);
    assign my_p = 42'(my_n) * 42'(K100_S28);
    assign hb_p = 42'(hb_n) * 42'(K100_S28);

    logic [12:0] r_we;
    logic [12:0] r_he;
    logic [11:0] r_hw;
    logic [11:0] r_hh;
    logic [11:0] r_wh2;
    logic [11:0] r_hh2;
    logic [10:0] r_mx;
    logic [10:0] r_my;
    logic [12:0] r_hbase;

    always_ff @(posedge i_clk) begin
        r_we    <= w_e;
        r_he    <= h_e;
        r_wh2   <= w_e[12:1];
        r_hh2   <= h_e[12:1];
        r_hw    <= (w_e[12:1] == 12'd0) ? 12'd1 : w_e[12:1];
        r_hh    <= (h_e[12:1] == 12'd0) ? 12'd1 : h_e[12:1];
        r_mx    <= 11'(mx_p >> 28);
        r_my    <= 11'(my_p >> 28);
        r_hbase <= 13'(hb_p >> 28);
    end

    // stage control
    logic [NS-1:0] r_v;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_v[NS-1] || !i_stall;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NS-1];

    // stage 0: input word
    logic [11:0] r_x0;
    logic [11:0] r_y0;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x0 <= i_pixel_x;
            r_y0 <= i_pixel_y;
        end
    end

    // stage 1: hash products, offsets
    logic [31:0]        hash_n;
    logic signed [12:0] hx_s;
    logic signed [12:0] vy_s;
    logic [11:0]        hxa;
    logic [11:0]        vya;
    logic signed [12:0] dx_c;
    logic signed [12:0] dy_c;

    assign hash_n = {20'd0, r_x0} * HASH_C1 + {20'd0, r_y0} * HASH_C2;
    assign hx_s   = $signed({1'b0, r_x0}) - $signed({1'b0, r_wh2});
    assign vy_s   = $signed({1'b0, r_y0}) - $signed({1'b0, r_hh2});
    assign hxa    = hx_s[12] ? 12'(-hx_s) : hx_s[11:0];
    assign vya    = vy_s[12] ? 12'(-vy_s) : vy_s[11:0];
    assign dx_c   = $signed({1'b0, r_x0}) - $signed({2'b00, r_mx});
    assign dy_c   = $signed({1'b0, r_y0}) - $signed({2'b00, r_my});

    logic [31:0]        r_n1;
    logic signed [12:0] r_dx1;
    logic signed [12:0] r_dy1;
    logic [11:0]        r_hxa1;
    logic [11:0]        r_y1;
    logic [11:0]        r_y2;
    logic [11:0]        r_y3;
    logic               r_wash [1:13];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_n1    <= hash_n;
            r_dx1   <= dx_c;
            r_dy1   <= dy_c;
            r_hxa1  <= hxa;
            r_y1    <= r_y0;
            r_wash[1] <= !r_y0[6];
        end
    end

    for (genvar s = 2; s <= 13; s++) begin : g_wash
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_wash[s] <= r_wash[s-1];
            end
        end
    end

    // dividers, stages 1 to 10
    logic [8:0] q_tx;
    logic [8:0] q_ty;
    logic [8:0] q_vx;
    logic [8:0] q_vy;

    pwp_div u_div_tx (
        .i_clk (i_clk), .i_en (en[10:1]),
        .i_num ({r_x0, 8'd0}), .i_den (r_we), .o_quo (q_tx)
    );
    pwp_div u_div_ty (
        .i_clk (i_clk), .i_en (en[10:1]),
        .i_num ({r_y0, 8'd0}), .i_den (r_he), .o_quo (q_ty)
    );
    pwp_div u_div_vx (
        .i_clk (i_clk), .i_en (en[10:1]),
        .i_num ({hxa, 8'd0}), .i_den ({1'b0, r_hw}), .o_quo (q_vx)
    );
    pwp_div u_div_vy (
        .i_clk (i_clk), .i_en (en[10:1]),
        .i_num ({vya, 8'd0}), .i_den ({1'b0, r_hh}), .o_quo (q_vy)
    );

    // stage 2: hash mix, squares
    logic [31:0]        hash_k;
    logic [31:0]        hash_m;
    logic signed [25:0] dxx;
    logic signed [25:0] dyy;
    logic [23:0]        hxx;

    assign hash_k = r_n1 ^ (r_n1 >> 13);
    assign hash_m = hash_k * HASH_C3;
    assign dxx    = r_dx1 * r_dx1;
    assign dyy    = r_dy1 * r_dy1;
    assign hxx    = {12'd0, r_hxa1} * {12'd0, r_hxa1};

    logic [31:0] r_m2;
    logic [23:0] r_dxx2;
    logic [23:0] r_dyy2;
    logic [23:0] r_hxx2;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_m2   <= hash_m;
            r_dxx2 <= dxx[23:0];
            r_dyy2 <= dyy[23:0];
            r_hxx2 <= hxx;
            r_y2   <= r_y1;
        end
    end

    // stage 3: dither bits, distance, parabola
    logic [49:0] hq_p;
    assign hq_p = 50'(r_hxx2) * 50'(K20000_S40);

    logic [1:0]  r_h [3:10];
    logic [24:0] r_d2_3;
    logic [9:0]  r_hq3;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_h[3] <= r_m2[1:0] ^ r_m2[17:16];
            r_d2_3 <= {1'b0, r_dxx2} + {1'b0, r_dyy2};
            r_hq3  <= 10'(hq_p >> 40);
            r_y3   <= r_y2;
        end
    end

    for (genvar s = 4; s <= 10; s++) begin : g_hash
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_h[s] <= r_h[s-1];
            end
        end
    end

    // stage 4: glow falloff, hill edge
    logic [48:0] sq_p;
    logic [13:0] hill;
    logic [13:0] dh;

    assign sq_p = 49'({r_d2_3[15:0], 8'd0}) * 49'(K40000_S40);
    assign hill = 14'(r_hbase) + 14'(r_hq3);
    assign dh   = {2'b00, r_y3} - hill;

    logic       r_near4;
    logic [7:0] r_sq4;
    logic       r_above4;
    logic [6:0] r_dh4;

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_near4  <= r_d2_3 < 25'(SUN_R2);
            r_sq4    <= 8'(sq_p >> 40);
            r_above4 <= {2'b00, r_y3} > hill;
            r_dh4    <= (dh >= 14'(HILL_DSAT)) ? 7'(HILL_DSAT) : dh[6:0];
        end
    end

    // stage 5: layer weights
    logic [8:0]  fall;
    logic [16:0] sw_p;
    logic [27:0] t_p;
    logic [7:0]  hill_t;

    assign fall   = 9'd256 - {1'b0, r_sq4};
    assign sw_p   = 17'(fall) * 17'(K6_S10);
    assign t_p    = 28'({r_dh4, 8'd0}) * 28'(K100_S19);
    assign hill_t = (r_dh4 == 7'(HILL_DSAT)) ? 8'(HILL_TMAX) : 8'(t_p >> 19);

    logic [5:0] r_sunw [5:12];
    logic [7:0] r_hillw [5:14];

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_sunw[5]  <= r_near4 ? 6'(sw_p >> 10) : 6'd0;
            r_hillw[5] <= r_above4 ? 8'({1'b0, hill_t[7:1]} + 8'(HILL_TOFS)) : 8'd0;
        end
    end

    for (genvar s = 6; s <= 12; s++) begin : g_sunw
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_sunw[s] <= r_sunw[s-1];
            end
        end
    end

    for (genvar s = 6; s <= 14; s++) begin : g_hillw
        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_hillw[s] <= r_hillw[s-1];
            end
        end
    end

    // stage 11: horizontal gradients, dithered vertical weight
    logic signed [10:0] tys;
    logic [8:0]         tyw;
    logic [17:0]        vxx;
    logic [17:0]        vyy;

    assign tys = $signed({2'b00, q_ty}) + $signed({9'd0, r_h[10]}) - 11'sd1;
    assign vxx = {9'd0, q_vx} * {9'd0, q_vx};
    assign vyy = {9'd0, q_vy} * {9'd0, q_vy};

    always_comb begin
        if (tys < 0) begin
            tyw = 9'd0;
        end else if (tys > 11'sd256) begin
            tyw = 9'd256;
        end else begin
            tyw = tys[8:0];
        end
    end

    t_rgb        r_top11;
    t_rgb        r_bot11;
    logic [8:0]  r_tyw11;
    logic [17:0] r_vxx11;
    logic [17:0] r_vyy11;

    always_ff @(posedge i_clk) begin
        if (en[11]) begin
            r_top11 <= blend(palette(r_theme, SLOT_SKY_L), palette(r_theme, SLOT_SKY_R),
                             {1'b0, q_tx});
            r_bot11 <= blend(palette(r_theme, SLOT_MIST_L), palette(r_theme, SLOT_MIST_R),
                             {1'b0, q_tx});
            r_tyw11 <= tyw;
            r_vxx11 <= vxx;
            r_vyy11 <= vyy;
        end
    end

    // stage 12: vertical gradient
    t_rgb        r_col12;
    logic [18:0] r_vs12;

    always_ff @(posedge i_clk) begin
        if (en[12]) begin
            r_col12 <= blend(r_top11, r_bot11, {1'b0, r_tyw11});
            r_vs12  <= {1'b0, r_vxx11} + {1'b0, r_vyy11};
        end
    end

    // stage 13: sun glow
    logic [36:0] v_p;
    assign v_p = 37'(r_vs12) * 37'(K800_S27);

    t_rgb       r_col13;
    logic [7:0] r_v13;

    always_ff @(posedge i_clk) begin
        if (en[13]) begin
            r_col13 <= blend(r_col12, palette(r_theme, SLOT_GLOW), {4'd0, r_sunw[12]});
            r_v13   <= (r_vs12 >= 19'(VIG_SAT_IN)) ? 8'(VIG_MAX) : 8'(v_p >> 27);
        end
    end

    // stage 14: band wash
    logic [15:0] vw_p;
    assign vw_p = 16'(r_v13) * 16'(K6_S10);

    t_rgb       r_col14;
    logic [4:0] r_vw14;
    logic [4:0] r_vw15;

    always_ff @(posedge i_clk) begin
        if (en[14]) begin
            r_col14 <= r_wash[13]
                ? blend(r_col13, palette(r_theme, SLOT_WASH), 10'(WASH_WGT))
                : r_col13;
            r_vw14  <= 5'(vw_p >> 10);
        end
    end

    // stage 15: hills
    t_rgb r_col15;

    always_ff @(posedge i_clk) begin
        if (en[15]) begin
            r_col15 <= blend(r_col14, palette(r_theme, SLOT_HILL), {2'b00, r_hillw[14]});
            r_vw15  <= r_vw14;
        end
    end

    // stage 16: vignette, output register
    t_rgb r_col16;

    always_ff @(posedge i_clk) begin
        if (en[16]) begin
            r_col16 <= blend(r_col15, palette(r_theme, SLOT_EDGE), {5'd0, r_vw15});
        end
    end

    assign o_rgb = r_col16;

endmodule

// File: tb/tb.sv
// Self-checking testbench for procedural_wallpaper_pixel: directed and random pixels
`timescale 1ns / 1ps
module tb
    import pwp_pkg::*;
();

    localparam int HANG_LIMIT = 6000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [11:0] i_pixel_x = '0;
    logic [11:0] i_pixel_y = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [23:0] o_rgb;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_WIDTH;
    logic [12:0] i_cfg_data = '0;

    procedural_wallpaper_pixel uut (.*);

    always #5 i_clk = ~i_clk;

    logic [12:0] scr_w = 13'd1024;
    logic [12:0] scr_h = 13'd768;
    logic [1:0]  pal_sel = THEME_DAY;

    t_rgb colour_q[$];
    int   errors = 0;
    int   sent = 0;
    int   idle_mode = 0;
    int   hold_cycles = 0;
    int   quiet = 0;

    function automatic t_rgb mix(t_rgb a, t_rgb b, longint wgt);
        t_rgb   res;
        longint ca;
        longint cb;
        longint c;
        res = '0;
        if (wgt <= 0) return a;
        if (wgt >= 256) return b;
        for (int ch = 0; ch < 3; ch++) begin
            ca = a[ch*8 +: 8];
            cb = b[ch*8 +: 8];
            c = ca + ((cb - ca) * wgt) / 256;
            res[ch*8 +: 8] = c[7:0];
        end
        return res;
    endfunction

    function automatic t_rgb shade(logic [11:0] px, logic [11:0] py);
        t_rgb        col;
        logic [31:0] n;
        logic [1:0]  th;
        longint x, y, w, h, tx, ty, mx, my, dx, dy, d2, hx, hill, t, hw, hh, vx, vy, v;
        x = px;
        y = py;
        w = scr_w;
        h = scr_h;
        if (w < 1) w = 1;
        if (h < 1) h = 1;
        if (w > 4096) w = 4096;
        if (h > 4096) h = 4096;
        th = (pal_sel == THEME_OCEAN || pal_sel == THEME_NIGHT) ? pal_sel : THEME_DAY;
        n = 32'(px) * HASH_C1 + 32'(py) * HASH_C2;
        n = (n ^ (n >> 13)) * HASH_C3;
        n = n ^ (n >> 16);
        ty = (y * 256) / h + longint'(n[1:0]) - 1;
        tx = (x * 256) / w;
        if (ty < 0) ty = 0;
        if (ty > 256) ty = 256;
        col = mix(mix(PAL_TAB[th][0], PAL_TAB[th][1], tx),
                  mix(PAL_TAB[th][2], PAL_TAB[th][3], tx), ty);
        mx = w * 24 / 100;
        my = h * 20 / 100;
        dx = x - mx;
        dy = y - my;
        d2 = dx * dx + dy * dy;
        if (d2 < 40000) col = mix(col, PAL_TAB[th][4], (256 - (d2 * 256) / 40000) / 6);
        if (py[6] == 1'b0) col = mix(col, PAL_TAB[th][5], 14);
        hx = x - w / 2;
        hill = h * 74 / 100 + (hx * hx) / 20000;
        if (y > hill) begin
            t = ((y - hill) * 256) / 100;
            if (t > 200) t = 200;
            col = mix(col, PAL_TAB[th][6], t / 2 + 40);
        end
        hw = w / 2;
        hh = h / 2;
        if (hw == 0) hw = 1;
        if (hh == 0) hh = 1;
        vx = (x - w / 2) * 256 / hw;
        vy = (y - h / 2) * 256 / hh;
        v = (vx * vx + vy * vy) / 800;
        if (v > 140) v = 140;
        return mix(col, PAL_TAB[th][7], v / 6);
    endfunction

    // receiver: check accepted words, then choose the next stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (colour_q.size() == 0) begin
                    $display("%0t: unexpected word rgb=%06h", $time, o_rgb);
                    errors++;
                end else begin
                    if (o_rgb !== colour_q[0]) begin
                        $display("%0t: rgb expected %06h actual %06h",
                                 $time, colour_q[0], o_rgb);
                        errors++;
                    end
                    void'(colour_q.pop_front());
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_stall <= 1'b1;
            end else if (idle_mode == 0) i_stall <= ($urandom_range(0, 99) < 78);
            else if (idle_mode == 1) i_stall <= ($urandom_range(0, 99) < 23);
            else i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= HANG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic cfg_write(logic [1:0] idx, logic [12:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  scr_w = val;
            CFG_HEIGHT: scr_h = val;
            default:    pal_sel = val[1:0];
        endcase
    endtask

    task automatic drain();
        while (colour_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [11:0] px, logic [11:0] py);
        int gap;
        gap = (idle_mode == 0) ? 23 : (idle_mode == 1) ? 78 : 0;
        while ($urandom_range(0, 99) < gap) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_pixel_x <= px;
        i_pixel_y <= py;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        colour_q.push_back(shade(px, py));
        sent++;
        idle_mode = (sent < 520) ? 0 : (sent < 1040) ? 1 : 2;
    endtask

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
    } t_coord;

    t_coord directed[] = '{
        '{12'd0, 12'd0}, '{12'd4095, 12'd4095}, '{12'd0, 12'd4095}, '{12'd4095, 12'd0},
        '{12'd1023, 12'd767}, '{12'd512, 12'd384}, '{12'd245, 12'd153},
        '{12'd445, 12'd153}, '{12'd100, 12'd63}, '{12'd100, 12'd64},
        '{12'd100, 12'd127}, '{12'd100, 12'd128}, '{12'd512, 12'd568},
        '{12'd512, 12'd569}, '{12'd512, 12'd700}, '{12'd0, 12'd700},
        '{12'd2730, 12'd1365}, '{12'd1365, 12'd2730}, '{12'd1024, 12'd768}
    };

    initial begin
        int ws[6] = '{1024, 1, 0, 4096, 8191, 640};
        int hs[6] = '{768, 1, 0, 4096, 8191, 480};
        int ts[6] = '{0, 1, 2, 3, 0, 1};
        int ew;
        int eh;
        logic [11:0] px;
        logic [11:0] py;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[k]) send_pixel(directed[k].x, directed[k].y);
        for (int ph = 0; ph < 6; ph++) begin
            i_valid <= 1'b0;
            drain();
            cfg_write(CFG_WIDTH, 13'(ws[ph]));
            cfg_write(CFG_HEIGHT, 13'(hs[ph]));
            cfg_write(CFG_THEME, 13'(ts[ph]));
            ew = (ws[ph] < 1) ? 1 : (ws[ph] > 4096) ? 4096 : ws[ph];
            eh = (hs[ph] < 1) ? 1 : (hs[ph] > 4096) ? 4096 : hs[ph];
            for (int i = 0; i < 260; i++) begin
                if (ph == 2 && i == 50) hold_cycles = 300;
                if (ph == 3 && i == 100) begin
                    i_valid <= 1'b0;
                    while (colour_q.size() != 0) @(posedge i_clk);
                end
                if ($urandom_range(0, 9) < 8) begin
                    px = 12'($urandom_range(0, ew - 1));
                    py = 12'($urandom_range(0, eh - 1));
                end else begin
                    px = 12'($urandom);
                    py = 12'($urandom);
                end
                send_pixel(px, py);
            end
        end
        i_valid <= 1'b0;
        drain();
        if (errors == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: files.f
src/pwp_pkg.sv
src/pwp_div.sv
src/procedural_wallpaper_pixel.sv
tb/tb.sv
